@@ hdl/itoa_pkg.sv @@
package itoa_pkg;

	// default sizing
	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_WIDTH_DEF  = 32;

	// digit store and character counts
	localparam int DIGIT_DEPTH = 64;
	localparam int DIGIT_AW    = 6;
	localparam int COUNT_W     = 7;

	// fixed characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// base codes
	localparam logic [2:0] BASE_2  = 3'd0;
	localparam logic [2:0] BASE_8  = 3'd1;
	localparam logic [2:0] BASE_10 = 3'd2;
	localparam logic [2:0] BASE_16 = 3'd3;
	localparam logic [2:0] BASE_64 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_EXTRACT,
		ST_SETUP,
		ST_EMIT
	} itoa_state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD_RAW,
		OP_LOAD_BCD,
		OP_DABBLE,
		OP_EXTRACT
	} unit_op_t;

	typedef enum logic [1:0] {
		K_SPACE,
		K_MINUS,
		K_ZERO,
		K_DIGIT
	} char_kind_t;

	// control of the shared shift unit
	typedef struct packed {
		unit_op_t    op;
		logic [2:0]  shift;
	} unit_ctl_t;

	// write side of the digit store
	typedef struct packed {
		logic                en;
		logic [DIGIT_AW-1:0] addr;
		logic [5:0]          data;
	} ram_wr_t;

	// digit value to its character in the 64-symbol alphabet
	function automatic logic [7:0] itoa_glyph(input logic [5:0] d, input logic up);
		logic [7:0] g;
		g = CH_ZERO;
		case (d) inside
			[6'd0:6'd9]:   g = CH_ZERO + 8'(d);
			[6'd10:6'd15]: g = (up ? CH_UP_A : CH_LOW_A) + 8'(d - 6'd10);
			[6'd16:6'd35]: g = CH_LOW_A + 8'(d - 6'd10);
			[6'd36:6'd61]: g = CH_UP_A + 8'(d - 6'd36);
			6'd62:         g = CH_PLUS;
			default:       g = CH_SLASH;
		endcase
		return g;
	endfunction

endpackage

@@ hdl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter.
// A number is offered on magnitude, negative, base_select, pad_width,
// zero_pad and upper_hex with start high; it is taken at a clock edge where
// start is high and busy is low. The block then prints it as ASCII text, one
// character per word on character, marked by char_valid for one cycle, most
// significant first; last_char flags the final word of the number.
// Steps per number: base 10 first runs a binary-to-BCD pass through the
// shared shift unit, then every known base writes the digit store one digit
// per cycle (an unknown base with a nonzero value writes none), then a setup
// step follows, then one character is emitted per cycle.
// busy stays high until the last character has been shown; start is ignored
// meanwhile. Characters cannot be held off: each is valid for one cycle only.
// Reset clears the sequencer and the output strobe; the block comes up idle.
module integer_to_ascii_formatter
	import itoa_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] magnitude,
	input  logic        negative,
	input  logic [2:0]  base_select,
	input  logic [5:0]  pad_width,
	input  logic        zero_pad,
	input  logic        upper_hex,
	output logic        char_valid,
	output logic [7:0]  character,
	output logic        last_char
);

	localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	itoa_state_t          state_q, state_d;
	unit_ctl_t            uctl;
	ram_wr_t              wr;
	logic                 accept;
	logic                 issue;
	logic [5:0]           digit;
	logic                 rest_zero;
	logic [VALUE_BITS-1:0] mag;
	logic                 mag_zero;

	logic                 neg_q, zpad_q, hexup_q, nodig_q;
	logic [2:0]           shift_q;
	logic [COUNT_W-1:0]   width_q, ndig_q, pad_q, cnt_q, pos_q;
	logic [BIT_W-1:0]     bit_q;

	logic [COUNT_W-1:0]   total, pad_c, sum_c, lead, idx, raddr_full;
	char_kind_t           kind_c, kind_s1;
	logic                 valid_s1, last_s1;
	logic [5:0]           rd_data;

	assign mag      = magnitude[VALUE_BITS-1:0];
	assign mag_zero = (mag == '0);
	assign busy     = (state_q != ST_IDLE) || valid_s1;
	assign accept   = start && !busy;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit control
	always_comb begin
		state_d    = state_q;
		uctl.op    = OP_HOLD;
		uctl.shift = shift_q;
		wr.en      = 1'b0;
		wr.addr    = ndig_q[DIGIT_AW-1:0];
		wr.data    = digit;
		issue      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (base_select == BASE_10) begin
						uctl.op = OP_LOAD_BCD;
						state_d = ST_DABBLE;
					end else begin
						uctl.op = OP_LOAD_RAW;
						if (base_select > BASE_64 && !mag_zero) begin
							state_d = ST_SETUP;
						end else begin
							state_d = ST_EXTRACT;
						end
					end
				end
			end
			ST_DABBLE: begin
				uctl.op = OP_DABBLE;
				if (bit_q == '0) begin
					state_d = ST_EXTRACT;
				end
			end
			ST_EXTRACT: begin
				uctl.op = OP_EXTRACT;
				wr.en   = 1'b1;
				if (rest_zero || ndig_q == COUNT_W'(DIGIT_DEPTH - 1)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				issue = (pos_q < cnt_q);
				if (pos_q + COUNT_W'(1) >= cnt_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// item fields latched at acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= negative;
			zpad_q  <= zero_pad;
			hexup_q <= upper_hex && (base_select == BASE_16);
			nodig_q <= (base_select > BASE_64) && !mag_zero;
			if ({1'b0, pad_width} > COUNT_W'(MAX_WIDTH)) begin
				width_q <= COUNT_W'(MAX_WIDTH);
			end else begin
				width_q <= {1'b0, pad_width};
			end
			case (base_select)
				BASE_2:  shift_q <= 3'd1;
				BASE_8:  shift_q <= 3'd3;
				BASE_64: shift_q <= 3'd6;
				default: shift_q <= 3'd4;
			endcase
		end
	end

	// layout of the printed field
	assign total = ndig_q + COUNT_W'(neg_q);
	assign pad_c = (width_q > total) ? width_q - total : '0;
	assign sum_c = pad_c + total;
	assign lead  = COUNT_W'(neg_q);

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			ndig_q <= '0;
			pad_q  <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					bit_q  <= BIT_W'(VALUE_BITS - 1);
					ndig_q <= '0;
				end
				ST_DABBLE: begin
					bit_q <= bit_q - BIT_W'(1);
				end
				ST_EXTRACT: begin
					ndig_q <= ndig_q + COUNT_W'(1);
				end
				ST_SETUP: begin
					pad_q <= pad_c;
					cnt_q <= (sum_c > COUNT_W'(DIGIT_DEPTH)) ? COUNT_W'(DIGIT_DEPTH) : sum_c;
					pos_q <= '0;
				end
				ST_EMIT: begin
					pos_q <= pos_q + COUNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// character kind at the current position
	always_comb begin
		if (zpad_q) begin
			if (neg_q && pos_q == '0) begin
				kind_c = K_MINUS;
			end else if (pos_q < pad_q + lead) begin
				kind_c = K_ZERO;
			end else begin
				kind_c = K_DIGIT;
			end
		end else begin
			if (pos_q < pad_q) begin
				kind_c = K_SPACE;
			end else if (neg_q && pos_q == pad_q) begin
				kind_c = K_MINUS;
			end else begin
				kind_c = K_DIGIT;
			end
		end
	end

	// digits come out of the store most significant first
	assign idx        = pos_q - pad_q - lead;
	assign raddr_full = ndig_q - COUNT_W'(1) - idx;

	// output stage, aligned with the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= kind_c;
			last_s1 <= (pos_q + COUNT_W'(1) == cnt_q);
		end
	end

	itoa_shift_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (uctl),
		.load_value(mag),
		.digit     (digit),
		.rest_zero (rest_zero)
	);

	itoa_digit_ram u_ram (
		.clk    (clk),
		.wr     (wr),
		.rd_en  (issue),
		.rd_addr(raddr_full[DIGIT_AW-1:0]),
		.rd_data(rd_data)
	);

	// character word
	always_comb begin
		case (kind_s1)
			K_SPACE: character = CH_SPACE;
			K_MINUS: character = CH_MINUS;
			K_ZERO:  character = CH_ZERO;
			default: character = itoa_glyph(rd_data, hexup_q);
		endcase
	end

	assign char_valid = valid_s1;
	assign last_char  = valid_s1 && last_s1;

`ifndef ASSERT_OFF
	// an accepted number keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after acceptance");

	// no character word while digits are still being formed
	a_quiet_convert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DABBLE || state_q == ST_EXTRACT) |-> !char_valid)
		else $error("character word during conversion");

	// the final word is never followed by another one
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |=> !char_valid)
		else $error("character word after the last one");

	// digit count stays within the store
	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= COUNT_W'(DIGIT_DEPTH))
		else $error("digit count beyond store depth");

	// a number with no digits never enters extraction
	a_nodig_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXTRACT) |-> !nodig_q)
		else $error("digit extraction for an unknown base");
`endif

endmodule

@@ hdl/itoa_shift_unit.sv @@
module itoa_shift_unit
	import itoa_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  unit_ctl_t             ctl,
	input  logic [VALUE_BITS-1:0] load_value,
	output logic [5:0]            digit,
	output logic                  rest_zero
);

	localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int WORK_BITS  = 4 * BCD_DIGITS;

	logic [VALUE_BITS-1:0] bin_q;
	logic [WORK_BITS-1:0]  work_q;
	logic [WORK_BITS-1:0]  corr;
	logic [WORK_BITS-1:0]  shifted;
	logic [5:0]            mask;

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (work_q[4*i +: 4] >= 4'd5) begin
				corr[4*i +: 4] = work_q[4*i +: 4] + 4'd3;
			end else begin
				corr[4*i +: 4] = work_q[4*i +: 4];
			end
		end
	end

	// digit extraction for power-of-two radix and for the BCD digits
	always_comb begin
		case (ctl.shift)
			3'd1:    mask = 6'h01;
			3'd3:    mask = 6'h07;
			3'd4:    mask = 6'h0F;
			default: mask = 6'h3F;
		endcase
	end

	assign shifted   = work_q >> ctl.shift;
	assign digit     = work_q[5:0] & mask;
	assign rest_zero = (shifted == '0);

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			work_q <= '0;
		end else begin
			case (ctl.op)
				OP_LOAD_RAW: begin
					work_q <= {{(WORK_BITS-VALUE_BITS){1'b0}}, load_value};
				end
				OP_LOAD_BCD: begin
					work_q <= '0;
					bin_q  <= load_value;
				end
				OP_DABBLE: begin
					work_q <= {corr[WORK_BITS-2:0], bin_q[VALUE_BITS-1]};
					bin_q  <= {bin_q[VALUE_BITS-2:0], 1'b0};
				end
				OP_EXTRACT: begin
					work_q <= shifted;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/itoa_digit_ram.sv @@
module itoa_digit_ram
	import itoa_pkg::*;
(
	input  logic                clk,
	input  ram_wr_t             wr,
	input  logic                rd_en,
	input  logic [DIGIT_AW-1:0] rd_addr,
	output logic [5:0]          rd_data
);

	logic [5:0] mem [DIGIT_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

import itoa_pkg::*;

// expected text of each accepted number, compared word by word
class text_scoreboard;

	typedef struct {
		bit [7:0] ch;
		bit       last;
	} char_word_t;

	char_word_t pending_chars[$];
	int         failures;
	string      symbols = {"0123456789abcdefghijklmnopqrstuv",
		"wxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+/"};

	function new();
		failures = 0;
	endfunction

	function void note_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	// format one accepted number and queue its characters
	function void add_number(bit [63:0] mag, bit neg, bit [2:0] sel, bit [5:0] width_in,
			bit zpad, bit upper);
		bit [7:0]   digits_rev[64];
		bit [7:0]   line[$];
		bit [63:0]  v;
		bit [7:0]   d;
		int         idx;
		int         ndig;
		int         width;
		int         total;
		int         pad;
		char_word_t w;
		v = mag;
		ndig = 0;
		width = (width_in > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_in);

		// digits, least significant first
		if (v == 64'd0) begin
			digits_rev[0] = CH_ZERO;
			ndig = 1;
		end else if (sel <= BASE_64) begin
			while (v != 64'd0 && ndig < DIGIT_DEPTH) begin
				case (sel)
					BASE_2: begin
						idx = int'(v[0]);
						v = v >> 1;
					end
					BASE_8: begin
						idx = int'(v[2:0]);
						v = v >> 3;
					end
					BASE_10: begin
						idx = int'(v % 64'd10);
						v = v / 64'd10;
					end
					BASE_16: begin
						idx = int'(v[3:0]);
						v = v >> 4;
					end
					default: begin
						idx = int'(v[5:0]);
						v = v >> 6;
					end
				endcase
				d = symbols[idx];
				if (sel == BASE_16 && upper && d >= CH_LOW_A && d <= CH_LOW_A + 8'd5)
					d = d - CH_LOW_A + CH_UP_A;
				digits_rev[ndig] = d;
				ndig++;
			end
		end

		total = ndig + (neg ? 1 : 0);
		pad = (width > total) ? width - total : 0;

		// space padding, sign, zero padding, digits
		if (!zpad)
			repeat (pad) line.push_back(CH_SPACE);
		if (neg)
			line.push_back(CH_MINUS);
		if (zpad)
			repeat (pad) line.push_back(CH_ZERO);
		for (int i = ndig - 1; i >= 0; i--)
			line.push_back(digits_rev[i]);

		// overlong text is cut to the store depth
		while (line.size() > DIGIT_DEPTH)
			void'(line.pop_back());

		foreach (line[i]) begin
			w.ch = line[i];
			w.last = (i == line.size() - 1);
			pending_chars.push_back(w);
		end
	endfunction

	// compare one emitted word with the oldest expected character
	function void check_char(bit [7:0] ch, bit last);
		char_word_t w;
		if (pending_chars.size() == 0) begin
			note_failure($sformatf("unexpected word: char=%h last=%0b", ch, last));
			return;
		end
		w = pending_chars.pop_front();
		if (ch !== w.ch || last !== w.last)
			note_failure($sformatf("word mismatch: exp char=%h last=%0b, got char=%h last=%0b",
				w.ch, w.last, ch, last));
	endfunction

	function int outstanding();
		return pending_chars.size();
	endfunction

endclass

module testbench;

	localparam logic [2:0] BASE_UNDEF = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] magnitude = '0;
	logic        negative = 1'b0;
	logic [2:0]  base_select = BASE_10;
	logic [5:0]  pad_width = '0;
	logic        zero_pad = 1'b0;
	logic        upper_hex = 1'b0;
	logic        char_valid;
	logic [7:0]  character;
	logic        last_char;

	text_scoreboard sb = new();

	integer_to_ascii_formatter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.magnitude  (magnitude),
		.negative   (negative),
		.base_select(base_select),
		.pad_width  (pad_width),
		.zero_pad   (zero_pad),
		.upper_hex  (upper_hex),
		.char_valid (char_valid),
		.character  (character),
		.last_char  (last_char)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid)
				sb.check_char(character, last_char);
			if (start && !busy)
				sb.add_number(magnitude, negative, base_select, pad_width, zero_pad, upper_hex);
		end
	end

	// offer one number and hold it until the block takes it
	task automatic send_number(bit [63:0] mag, bit neg, bit [2:0] sel, bit [5:0] width,
			bit zpad, bit upper);
		start       <= 1'b1;
		magnitude   <= mag;
		negative    <= neg;
		base_select <= sel;
		pad_width   <= width;
		zero_pad    <= zpad;
		upper_hex   <= upper;
		do @(posedge clk); while (busy);
	endtask

	// random idle time on the sending side, mostly none or short
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 20);
		else
			n = $urandom_range(40, 200);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending until every expected word has come out
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0 || busy);
	endtask

	// one random number, biased toward well-formed bases
	task automatic send_random();
		bit [63:0] mag;
		bit [2:0]  sel;
		bit [5:0]  width;
		int        k;
		mag = {$urandom(), $urandom()};
		k = $urandom_range(0, 64);
		if (k < 64)
			mag = mag & ((64'd1 << k) - 64'd1);
		if ($urandom_range(0, 19) == 0)
			mag = '0;
		if ($urandom_range(0, 99) < 85)
			sel = 3'($urandom_range(BASE_2, BASE_64));
		else
			sel = 3'($urandom_range(BASE_64 + 1, BASE_UNDEF));
		if ($urandom_range(0, 3) == 0)
			width = 6'($urandom_range(0, 63));
		else
			width = 6'($urandom_range(0, MAX_WIDTH_DEF));
		send_number(mag, 1'($urandom), sel, width, 1'($urandom), 1'($urandom));
	endtask

	// stimulus
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero in several bases and paddings
		send_number(64'd0, 1'b0, BASE_10, 6'd0, 1'b0, 1'b0);
		send_number(64'd0, 1'b1, BASE_2, 6'd5, 1'b0, 1'b0);
		send_number(64'd0, 1'b0, BASE_UNDEF, 6'd3, 1'b1, 1'b0);
		idle_gap();
		// full-scale values in every base
		send_number('1, 1'b0, BASE_2, 6'd0, 1'b0, 1'b0);
		send_number('1, 1'b1, BASE_2, 6'd0, 1'b0, 1'b0);
		send_number('1, 1'b1, BASE_8, 6'd0, 1'b1, 1'b0);
		send_number('1, 1'b1, BASE_10, 6'd32, 1'b1, 1'b0);
		send_number('1, 1'b0, BASE_16, 6'd0, 1'b0, 1'b1);
		send_number('1, 1'b0, BASE_64, 6'd0, 1'b0, 1'b0);
		idle_gap();
		// hex letters both cases, a range of base-64 symbols
		send_number(64'hDEADBEEF, 1'b1, BASE_16, 6'd12, 1'b1, 1'b0);
		send_number(64'h0123456789ABCDEF, 1'b0, BASE_16, 6'd0, 1'b0, 1'b1);
		send_number(64'h0123456789ABCDEF, 1'b0, BASE_64, 6'd0, 1'b0, 1'b1);
		send_number(64'hFEDCBA9876543210, 1'b1, BASE_64, 6'd20, 1'b0, 1'b0);
		send_number(64'd1234567890, 1'b0, BASE_10, 6'd0, 1'b0, 1'b1);
		// unknown base: nothing at all, then padding and sign only
		send_number(64'd77, 1'b0, BASE_UNDEF, 6'd0, 1'b0, 1'b0);
		send_number(64'd77, 1'b1, BASE_64 + 3'd1, 6'd5, 1'b1, 1'b0);
		send_number(64'd77, 1'b0, BASE_64 + 3'd2, 6'd4, 1'b0, 1'b0);
		idle_gap();
		// widths: saturated, exact fit, one short
		send_number(64'd42, 1'b0, BASE_10, 6'd63, 1'b0, 1'b0);
		send_number(64'd42, 1'b1, BASE_10, 6'd63, 1'b1, 1'b0);
		send_number(64'd42, 1'b1, BASE_10, 6'd3, 1'b1, 1'b0);
		send_number(64'd42, 1'b1, BASE_10, 6'd2, 1'b0, 1'b0);
		send_number(64'd8, 1'b0, BASE_8, 6'd1, 1'b0, 1'b0);
		send_number(64'd255, 1'b1, BASE_2, 6'd32, 1'b1, 1'b0);
		wait_drained();

		// random part, with an occasional full drain
		for (int i = 0; i < 300; i++) begin
			send_random();
			if (i == 150 || $urandom_range(0, 99) == 0)
				wait_drained();
			else
				idle_gap();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.note_failure($sformatf("%0d words never came out", sb.outstanding()));
		if (sb.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ integer_to_ascii_formatter.f @@
hdl/itoa_pkg.sv
hdl/itoa_shift_unit.sv
hdl/itoa_digit_ram.sv
hdl/integer_to_ascii_formatter.sv
tb/testbench.sv
